>>> hdl/vtb_pkg.sv
// types, codes and bit positions shared by the box pair relations block
package vtb_pkg;

  localparam int BND_W = 64;
  localparam int FLG_W = 2;
  localparam int REL_W = 13;
  localparam int FLT_W = 3;

  typedef logic signed [BND_W-1:0] bnd_t;

  typedef struct packed {
    logic [FLG_W-1:0] flags;
    bnd_t             vlo;
    bnd_t             vhi;
    bnd_t             tlo;
    bnd_t             thi;
  } box_t;

  // lt: a below b, gt: b below a, eq: identical
  typedef struct packed {
    logic hx;
    logic ht;
    logic common;
    logic ovl;
    logic vlo_lt, vlo_gt, vlo_eq;
    logic vhi_lt, vhi_gt, vhi_eq;
    logic tlo_lt, tlo_gt, tlo_eq;
    logic thi_lt, thi_gt, thi_eq;
    logic a_left;
    logic a_right;
    logic a_before;
    logic a_after;
  } cmp_t;

  // intersection and union bounds per dimension
  typedef struct packed {
    bnd_t ivlo;
    bnd_t ivhi;
    bnd_t itlo;
    bnd_t ithi;
    bnd_t uvlo;
    bnd_t uvhi;
    bnd_t utlo;
    bnd_t uthi;
  } span_t;

  typedef enum logic [1:0] {
    BOX_OK           = 2'd0,
    BOX_EMPTY        = 2'd1,
    BOX_DIM_MISMATCH = 2'd2,
    BOX_GAP          = 2'd3
  } status_t;

  localparam logic KIND_INTERSECT = 1'b0;
  localparam logic KIND_UNION     = 1'b1;

  localparam logic [FLG_W-1:0] FLG_NONE = 2'd0;

  localparam logic signed [1:0] ORD_LESS    = -2'sd1;
  localparam logic signed [1:0] ORD_EQUAL   = 2'sd0;
  localparam logic signed [1:0] ORD_GREATER = 2'sd1;

  localparam int REL_CONTAINS   = 0;
  localparam int REL_CONTAINED  = 1;
  localparam int REL_OVERLAPS   = 2;
  localparam int REL_SAME       = 3;
  localparam int REL_ADJACENT   = 4;
  localparam int REL_LEFT       = 5;
  localparam int REL_OVERLEFT   = 6;
  localparam int REL_RIGHT      = 7;
  localparam int REL_OVERRIGHT  = 8;
  localparam int REL_BEFORE     = 9;
  localparam int REL_OVERBEFORE = 10;
  localparam int REL_AFTER      = 11;
  localparam int REL_OVERAFTER  = 12;

  localparam int FLT_NO_COMMON = 0;
  localparam int FLT_NO_VALUE  = 1;
  localparam int FLT_NO_TIME   = 2;

endpackage

>>> hdl/value_time_box_pair_relations_unit.sv
// top level of the value/time box pair relations unit
//
// Takes a pair of boxes, each with an optional Q32.32 value span and an
// optional microsecond time span, and returns the thirteen relation bits,
// the total order, strict equality, dimension faults and either the
// intersection or the union box (selected by kind) with its status.
//
// Input: a beat is taken at each clock edge where start is high and busy is
// low. busy is always low, so a new pair can be offered every cycle.
// Output: each result appears for exactly one cycle with done high; the
// receiver cannot stall, and there is no backpressure path.
// The pair is held in the input register and its results in the result register.
// Throughput: one pair per cycle, set by a single stage of parallel
// 64-bit compares and min/max muxing between the input and result registers.
// Reset (rst, synchronous) drops any pair in flight and clears done; no
// result comes out for a pair accepted before reset.
module value_time_box_pair_relations_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  output logic                               done,
  input  logic                               kind,
  input  logic [vtb_pkg::FLG_W-1:0]          flags_a,
  input  logic signed [vtb_pkg::BND_W-1:0]   vlo_a,
  input  logic signed [vtb_pkg::BND_W-1:0]   vhi_a,
  input  logic signed [vtb_pkg::BND_W-1:0]   tlo_a,
  input  logic signed [vtb_pkg::BND_W-1:0]   thi_a,
  input  logic [vtb_pkg::FLG_W-1:0]          flags_b,
  input  logic signed [vtb_pkg::BND_W-1:0]   vlo_b,
  input  logic signed [vtb_pkg::BND_W-1:0]   vhi_b,
  input  logic signed [vtb_pkg::BND_W-1:0]   tlo_b,
  input  logic signed [vtb_pkg::BND_W-1:0]   thi_b,
  output logic [vtb_pkg::REL_W-1:0]          relation_bits,
  output logic signed [1:0]                  order,
  output logic                               equal,
  output logic [vtb_pkg::FLT_W-1:0]          check_faults,
  output logic [1:0]                         box_status,
  output logic [vtb_pkg::FLG_W-1:0]          out_flags,
  output logic signed [vtb_pkg::BND_W-1:0]   out_vlo,
  output logic signed [vtb_pkg::BND_W-1:0]   out_vhi,
  output logic signed [vtb_pkg::BND_W-1:0]   out_tlo,
  output logic signed [vtb_pkg::BND_W-1:0]   out_thi
);
  import vtb_pkg::*;

  // input register
  logic  in_valid;
  logic  in_kind;
  box_t  in_a;
  box_t  in_b;

  cmp_t              cmp;
  span_t             span;
  logic [REL_W-1:0]  rel_next;
  logic signed [1:0] order_next;
  logic              equal_next;
  logic [FLT_W-1:0]  faults_next;
  status_t           status_next;
  box_t              res_next;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_kind <= kind;
      in_a    <= '{flags: flags_a, vlo: vlo_a, vhi: vhi_a, tlo: tlo_a, thi: thi_a};
      in_b    <= '{flags: flags_b, vlo: vlo_b, vhi: vhi_b, tlo: tlo_b, thi: thi_b};
    end
  end

  vtb_cmp u_cmp (
    .a (in_a),
    .b (in_b),
    .c (cmp),
    .s (span)
  );

  vtb_rel u_rel (
    .flags_a       (in_a.flags),
    .flags_b       (in_b.flags),
    .c             (cmp),
    .s             (span),
    .relation_bits (rel_next),
    .order         (order_next),
    .equal         (equal_next),
    .check_faults  (faults_next)
  );

  vtb_box u_box (
    .kind       (in_kind),
    .flags_a    (in_a.flags),
    .flags_b    (in_b.flags),
    .c          (cmp),
    .s          (span),
    .box_status (status_next),
    .res        (res_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      relation_bits <= rel_next;
      order         <= order_next;
      equal         <= equal_next;
      check_faults  <= faults_next;
      box_status    <= status_next;
      out_flags     <= res_next.flags;
      out_vlo       <= res_next.vlo;
      out_vhi       <= res_next.vhi;
      out_tlo       <= res_next.tlo;
      out_thi       <= res_next.thi;
    end
  end

  a_done_follows_accept: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, 2))
    else $error("result beat without an accepted input beat");

  a_fail_box_zero: assert property (@(posedge clk) disable iff (rst)
    (done && box_status != BOX_OK) |->
      (out_flags == '0 && out_vlo == '0 && out_vhi == '0 &&
       out_tlo == '0 && out_thi == '0))
    else $error("box fields not cleared on failed status");

  a_ok_box_has_dim: assert property (@(posedge clk) disable iff (rst)
    (done && box_status == BOX_OK) |-> out_flags != FLG_NONE)
    else $error("good box result with no dimension");

  a_no_common_rel: assert property (@(posedge clk) disable iff (rst)
    (done && check_faults[FLT_NO_COMMON]) |->
      (relation_bits[REL_ADJACENT:REL_CONTAINS] == '0 && box_status != BOX_OK))
    else $error("relation or box given without a common dimension");

  a_equal_order: assert property (@(posedge clk) disable iff (rst)
    (done && equal) |->
      (order == ORD_EQUAL &&
       relation_bits[REL_SAME] == !check_faults[FLT_NO_COMMON]))
    else $error("equal boxes not ordered equal or not same");

endmodule

>>> hdl/vtb_cmp.sv
// bound comparators and min/max selection shared by relations and box result
module vtb_cmp (
  input  vtb_pkg::box_t  a,
  input  vtb_pkg::box_t  b,
  output vtb_pkg::cmp_t  c,
  output vtb_pkg::span_t s
);
  import vtb_pkg::*;

  always_comb begin
    c.hx     = a.flags[0] & b.flags[0];
    c.ht     = a.flags[1] & b.flags[1];
    c.common = c.hx | c.ht;

    c.vlo_lt = a.vlo < b.vlo;
    c.vlo_gt = b.vlo < a.vlo;
    c.vlo_eq = a.vlo == b.vlo;
    c.vhi_lt = a.vhi < b.vhi;
    c.vhi_gt = b.vhi < a.vhi;
    c.vhi_eq = a.vhi == b.vhi;
    c.tlo_lt = a.tlo < b.tlo;
    c.tlo_gt = b.tlo < a.tlo;
    c.tlo_eq = a.tlo == b.tlo;
    c.thi_lt = a.thi < b.thi;
    c.thi_gt = b.thi < a.thi;
    c.thi_eq = a.thi == b.thi;

    c.a_left   = a.vhi < b.vlo;
    c.a_right  = b.vhi < a.vlo;
    c.a_before = a.thi < b.tlo;
    c.a_after  = b.thi < a.tlo;

    // disjoint in any shared dimension kills the overlap
    c.ovl = c.common
          & ~(c.hx & (c.a_left | c.a_right))
          & ~(c.ht & (c.a_before | c.a_after));

    s.ivlo = c.vlo_lt ? b.vlo : a.vlo;
    s.ivhi = c.vhi_gt ? b.vhi : a.vhi;
    s.itlo = c.tlo_lt ? b.tlo : a.tlo;
    s.ithi = c.thi_gt ? b.thi : a.thi;
    s.uvlo = c.vlo_gt ? b.vlo : a.vlo;
    s.uvhi = c.vhi_lt ? b.vhi : a.vhi;
    s.utlo = c.tlo_gt ? b.tlo : a.tlo;
    s.uthi = c.thi_lt ? b.thi : a.thi;
  end

endmodule

>>> hdl/vtb_rel.sv
// relation predicates, total order, equality and dimension faults
module vtb_rel (
  input  logic [vtb_pkg::FLG_W-1:0]  flags_a,
  input  logic [vtb_pkg::FLG_W-1:0]  flags_b,
  input  vtb_pkg::cmp_t              c,
  input  vtb_pkg::span_t             s,
  output logic [vtb_pkg::REL_W-1:0]  relation_bits,
  output logic signed [1:0]          order,
  output logic                       equal,
  output logic [vtb_pkg::FLT_W-1:0]  check_faults
);
  import vtb_pkg::*;

  logic adj;

  always_comb begin
    adj = (c.hx & (s.ivlo == s.ivhi)) | (c.ht & (s.itlo == s.ithi));

    relation_bits = '0;
    if (c.common) begin
      relation_bits[REL_CONTAINS]  = ~(c.hx & (c.vlo_gt | c.vhi_lt))
                                   & ~(c.ht & (c.tlo_gt | c.thi_lt));
      relation_bits[REL_CONTAINED] = ~(c.hx & (c.vlo_lt | c.vhi_gt))
                                   & ~(c.ht & (c.tlo_lt | c.thi_gt));
      relation_bits[REL_OVERLAPS]  = c.ovl;
      relation_bits[REL_SAME]      = (~c.hx | (c.vlo_eq & c.vhi_eq))
                                   & (~c.ht | (c.tlo_eq & c.thi_eq));
      relation_bits[REL_ADJACENT]  = c.ovl & adj;
    end
    if (c.hx) begin
      relation_bits[REL_LEFT]      = c.a_left;
      relation_bits[REL_OVERLEFT]  = ~c.vhi_gt;
      relation_bits[REL_RIGHT]     = c.a_right;
      relation_bits[REL_OVERRIGHT] = ~c.vlo_lt;
    end
    if (c.ht) begin
      relation_bits[REL_BEFORE]     = c.a_before;
      relation_bits[REL_OVERBEFORE] = ~c.thi_gt;
      relation_bits[REL_AFTER]      = c.a_after;
      relation_bits[REL_OVERAFTER]  = ~c.tlo_lt;
    end
  end

  // first differing key decides: tlo, vlo, thi, vhi, then flags
  always_comb begin
    if (c.ht && !c.tlo_eq) begin
      order = c.tlo_lt ? ORD_LESS : ORD_GREATER;
    end else if (c.hx && !c.vlo_eq) begin
      order = c.vlo_lt ? ORD_LESS : ORD_GREATER;
    end else if (c.ht && !c.thi_eq) begin
      order = c.thi_lt ? ORD_LESS : ORD_GREATER;
    end else if (c.hx && !c.vhi_eq) begin
      order = c.vhi_lt ? ORD_LESS : ORD_GREATER;
    end else if (flags_a < flags_b) begin
      order = ORD_LESS;
    end else if (flags_a > flags_b) begin
      order = ORD_GREATER;
    end else begin
      order = ORD_EQUAL;
    end
  end

  always_comb begin
    equal = (flags_a == flags_b) & c.vlo_eq & c.vhi_eq & c.tlo_eq & c.thi_eq;
    check_faults                = '0;
    check_faults[FLT_NO_COMMON] = ~c.common;
    check_faults[FLT_NO_VALUE]  = ~c.hx;
    check_faults[FLT_NO_TIME]   = ~c.ht;
  end

endmodule

>>> hdl/vtb_box.sv
// intersection or union box with its status
module vtb_box (
  input  logic                       kind,
  input  logic [vtb_pkg::FLG_W-1:0]  flags_a,
  input  logic [vtb_pkg::FLG_W-1:0]  flags_b,
  input  vtb_pkg::cmp_t              c,
  input  vtb_pkg::span_t             s,
  output vtb_pkg::status_t           box_status,
  output vtb_pkg::box_t              res
);
  import vtb_pkg::*;

  always_comb begin
    res        = '0;
    box_status = BOX_OK;
    if (kind == KIND_INTERSECT) begin
      if (!c.ovl) begin
        box_status = BOX_EMPTY;
      end else begin
        res.flags = {c.ht, c.hx};
        if (c.hx) begin
          res.vlo = s.ivlo;
          res.vhi = s.ivhi;
        end
        if (c.ht) begin
          res.tlo = s.itlo;
          res.thi = s.ithi;
        end
      end
    end else begin
      if (flags_a != flags_b || flags_a == FLG_NONE) begin
        box_status = BOX_DIM_MISMATCH;
      end else if (!c.ovl) begin
        box_status = BOX_GAP;
      end else begin
        res.flags = flags_a;
        if (c.hx) begin
          res.vlo = s.uvlo;
          res.vhi = s.uvhi;
        end
        if (c.ht) begin
          res.tlo = s.utlo;
          res.thi = s.uthi;
        end
      end
    end
  end

endmodule

>>> verif/tb_top.sv
// testbench for the value/time box pair relations unit
`timescale 1ns / 100ps

module tb_top;
  import vtb_pkg::*;

  localparam int   IDLE_LIMIT = 500;
  localparam int   PRINT_CAP  = 100;
  localparam int   RAND_PAIRS = 1900;
  localparam bnd_t BND_MIN    = {1'b1, {(BND_W-1){1'b0}}};
  localparam bnd_t BND_MAX    = {1'b0, {(BND_W-1){1'b1}}};

  typedef struct packed {
    logic kind;
    box_t a;
    box_t b;
  } pair_t;

  typedef struct packed {
    logic [REL_W-1:0] rel;
    logic [1:0]       ord;
    logic             eq;
    logic [FLT_W-1:0] faults;
    status_t          status;
    logic [FLG_W-1:0] flags;
    bnd_t             vlo;
    bnd_t             vhi;
    bnd_t             tlo;
    bnd_t             thi;
  } res_t;

  logic  clk = 1'b0;
  logic  rst = 1'b1;
  logic  start = 1'b0;
  pair_t drv = '0;
  logic  busy, done;
  logic [REL_W-1:0] relation_bits;
  logic signed [1:0] order;
  logic equal;
  logic [FLT_W-1:0] check_faults;
  logic [1:0] box_status;
  logic [FLG_W-1:0] out_flags;
  logic signed [BND_W-1:0] out_vlo, out_vhi, out_tlo, out_thi;

  pair_t pending_pairs[$];
  res_t  expected_results[$];
  int    mismatches = 0;
  int    gap_left = 0;
  int    idle_cycles = 0;
  logic  beat_taken = 1'b0;

  always #5 clk = ~clk;

  value_time_box_pair_relations_unit dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
    .kind(drv.kind),
    .flags_a(drv.a.flags), .vlo_a(drv.a.vlo), .vhi_a(drv.a.vhi),
    .tlo_a(drv.a.tlo), .thi_a(drv.a.thi),
    .flags_b(drv.b.flags), .vlo_b(drv.b.vlo), .vhi_b(drv.b.vhi),
    .tlo_b(drv.b.tlo), .thi_b(drv.b.thi),
    .relation_bits(relation_bits), .order(order), .equal(equal),
    .check_faults(check_faults), .box_status(box_status), .out_flags(out_flags),
    .out_vlo(out_vlo), .out_vhi(out_vhi), .out_tlo(out_tlo), .out_thi(out_thi)
  );

  function automatic logic lt(bnd_t x, bnd_t y);
    return x < y;
  endfunction

  function automatic logic signed [1:0] cmp_bnd(bnd_t x, bnd_t y);
    if (lt(x, y)) return ORD_LESS;
    if (lt(y, x)) return ORD_GREATER;
    return ORD_EQUAL;
  endfunction

  function automatic res_t predict_box_pair(pair_t p);
    res_t r;
    box_t a, b;
    logic hx, ht, common, ovl, adj;
    bnd_t ivlo, ivhi, itlo, ithi;
    a = p.a;
    b = p.b;
    r = '0;
    hx = a.flags[0] & b.flags[0];
    ht = a.flags[1] & b.flags[1];
    common = hx | ht;
    r.faults[FLT_NO_COMMON] = !common;
    r.faults[FLT_NO_VALUE]  = !hx;
    r.faults[FLT_NO_TIME]   = !ht;
    ovl = common && !(hx && (lt(a.vhi, b.vlo) || lt(b.vhi, a.vlo)))
                 && !(ht && (lt(a.thi, b.tlo) || lt(b.thi, a.tlo)));
    ivlo = lt(a.vlo, b.vlo) ? b.vlo : a.vlo;
    ivhi = lt(b.vhi, a.vhi) ? b.vhi : a.vhi;
    itlo = lt(a.tlo, b.tlo) ? b.tlo : a.tlo;
    ithi = lt(b.thi, a.thi) ? b.thi : a.thi;
    if (common) begin
      r.rel[REL_CONTAINS] = !(hx && (lt(b.vlo, a.vlo) || lt(a.vhi, b.vhi)))
                         && !(ht && (lt(b.tlo, a.tlo) || lt(a.thi, b.thi)));
      r.rel[REL_CONTAINED] = !(hx && (lt(a.vlo, b.vlo) || lt(b.vhi, a.vhi)))
                          && !(ht && (lt(a.tlo, b.tlo) || lt(b.thi, a.thi)));
      r.rel[REL_OVERLAPS] = ovl;
      r.rel[REL_SAME] = (!hx || (a.vlo == b.vlo && a.vhi == b.vhi))
                     && (!ht || (a.tlo == b.tlo && a.thi == b.thi));
      // a shared dimension that shrinks to a point makes the pair adjacent
      adj = (hx && ivlo == ivhi) || (ht && itlo == ithi);
      r.rel[REL_ADJACENT] = ovl && adj;
    end
    if (hx) begin
      r.rel[REL_LEFT]      = lt(a.vhi, b.vlo);
      r.rel[REL_OVERLEFT]  = !lt(b.vhi, a.vhi);
      r.rel[REL_RIGHT]     = lt(b.vhi, a.vlo);
      r.rel[REL_OVERRIGHT] = !lt(a.vlo, b.vlo);
    end
    if (ht) begin
      r.rel[REL_BEFORE]     = lt(a.thi, b.tlo);
      r.rel[REL_OVERBEFORE] = !lt(b.thi, a.thi);
      r.rel[REL_AFTER]      = lt(b.thi, a.tlo);
      r.rel[REL_OVERAFTER]  = !lt(a.tlo, b.tlo);
    end

    r.ord = ORD_EQUAL;
    if (ht) r.ord = cmp_bnd(a.tlo, b.tlo);
    if (r.ord == ORD_EQUAL && hx) r.ord = cmp_bnd(a.vlo, b.vlo);
    if (r.ord == ORD_EQUAL && ht) r.ord = cmp_bnd(a.thi, b.thi);
    if (r.ord == ORD_EQUAL && hx) r.ord = cmp_bnd(a.vhi, b.vhi);
    if (r.ord == ORD_EQUAL)
      r.ord = (a.flags < b.flags) ? ORD_LESS : (a.flags > b.flags) ? ORD_GREATER : ORD_EQUAL;

    r.eq = (a == b);

    if (p.kind == KIND_INTERSECT) begin
      if (!ovl) begin
        r.status = BOX_EMPTY;
      end else begin
        r.status = BOX_OK;
        r.flags = {ht, hx};
        if (hx) begin
          r.vlo = ivlo;
          r.vhi = ivhi;
        end
        if (ht) begin
          r.tlo = itlo;
          r.thi = ithi;
        end
      end
    end else if (a.flags != b.flags || a.flags == FLG_NONE) begin
      r.status = BOX_DIM_MISMATCH;
    end else if (!ovl) begin
      r.status = BOX_GAP;
    end else begin
      r.status = BOX_OK;
      r.flags = a.flags;
      if (hx) begin
        r.vlo = lt(b.vlo, a.vlo) ? b.vlo : a.vlo;
        r.vhi = lt(a.vhi, b.vhi) ? b.vhi : a.vhi;
      end
      if (ht) begin
        r.tlo = lt(b.tlo, a.tlo) ? b.tlo : a.tlo;
        r.thi = lt(a.thi, b.thi) ? b.thi : a.thi;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("tb: %0t %s got %h want %h", $realtime, what, got, want);
  endtask

  task automatic check_result(res_t want);
    if (relation_bits != want.rel) report_mismatch("relation_bits", relation_bits, want.rel);
    if (order != want.ord) report_mismatch("order", order, want.ord);
    if (equal != want.eq) report_mismatch("equal", equal, want.eq);
    if (check_faults != want.faults) report_mismatch("check_faults", check_faults, want.faults);
    if (box_status != want.status) report_mismatch("box_status", box_status, want.status);
    if (out_flags != want.flags) report_mismatch("out_flags", out_flags, want.flags);
    if (out_vlo != want.vlo) report_mismatch("out_vlo", out_vlo, want.vlo);
    if (out_vhi != want.vhi) report_mismatch("out_vhi", out_vhi, want.vhi);
    if (out_tlo != want.tlo) report_mismatch("out_tlo", out_tlo, want.tlo);
    if (out_thi != want.thi) report_mismatch("out_thi", out_thi, want.thi);
  endtask

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 65) return 0;
    if (roll < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic bnd_t rand_bnd();
    return {$urandom, $urandom};
  endfunction

  function automatic bnd_t extreme_bnd();
    case ($urandom_range(0, 4))
      0: return BND_MIN;
      1: return BND_MAX;
      2: return '0;
      3: return '1;
      default: return bnd_t'(1);
    endcase
  endfunction

  // apart from a fully random mode, both boxes draw their bounds from a few
  // nearby points so that equal, touching, nested and disjoint spans all come up often
  function automatic void pick_spans(output bnd_t alo, output bnd_t ahi,
                                     output bnd_t blo, output bnd_t bhi);
    bnd_t pt[4];
    bnd_t base, step, tmp;
    int mode;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      alo = rand_bnd();
      ahi = rand_bnd();
      blo = rand_bnd();
      bhi = rand_bnd();
      return;
    end
    base = (mode < 4) ? extreme_bnd() : rand_bnd();
    step = (mode < 7) ? bnd_t'($urandom_range(1, 4)) : bnd_t'($urandom_range(1, 1 << 20));
    for (int i = 0; i < 4; i++)
      pt[i] = base + step * bnd_t'($urandom_range(0, 4));
    if ($urandom_range(0, 11) != 0) begin
      if (lt(pt[1], pt[0])) begin
        tmp = pt[0]; pt[0] = pt[1]; pt[1] = tmp;
      end
      if (lt(pt[3], pt[2])) begin
        tmp = pt[2]; pt[2] = pt[3]; pt[3] = tmp;
      end
    end
    alo = pt[0];
    ahi = pt[1];
    blo = pt[2];
    bhi = pt[3];
  endfunction

  function automatic logic [FLG_W-1:0] rand_flags();
    if ($urandom_range(0, 19) == 0) return FLG_NONE;
    return 2'($urandom_range(1, 3));
  endfunction

  function automatic pair_t rand_pair();
    pair_t p;
    p.kind = 1'($urandom_range(0, 1));
    pick_spans(p.a.vlo, p.a.vhi, p.b.vlo, p.b.vhi);
    pick_spans(p.a.tlo, p.a.thi, p.b.tlo, p.b.thi);
    p.a.flags = rand_flags();
    p.b.flags = ($urandom_range(0, 1) == 0) ? p.a.flags : rand_flags();
    if ($urandom_range(0, 19) == 0) p.b = p.a;
    return p;
  endfunction

  function automatic box_t mk_box(logic [FLG_W-1:0] f, bnd_t vlo, bnd_t vhi,
                                  bnd_t tlo, bnd_t thi);
    box_t bx;
    bx.flags = f;
    bx.vlo = vlo;
    bx.vhi = vhi;
    bx.tlo = tlo;
    bx.thi = thi;
    return bx;
  endfunction

  task automatic add_pair(logic k, box_t a, box_t b);
    pair_t p;
    p.kind = k;
    p.a = a;
    p.b = b;
    pending_pairs.push_back(p);
  endtask

  // driver: a beat stays on the ports until taken, then a gap or the next one
  always @(negedge clk) begin
    if (!rst && (!start || beat_taken)) begin
      if (gap_left > 0) begin
        start <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (pending_pairs.size() > 0) begin
        drv <= pending_pairs.pop_front();
        start <= 1'b1;
        gap_left <= pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check the result first, then queue the prediction for a new beat
  always @(posedge clk) begin
    beat_taken <= !rst && start && !busy;
    if (!rst) begin
      if (done) begin
        if (expected_results.size() == 0)
          report_mismatch("result with nothing pending", relation_bits, '0);
        else
          check_result(expected_results.pop_front());
      end
      if (start && !busy)
        expected_results.push_back(predict_box_pair(drv));
    end
  end

  always @(posedge clk) begin
    if (rst || done || (start && !busy))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    // full box pairs: identical, nested at the extremes, disjoint, touching
    add_pair(KIND_INTERSECT, mk_box(2'd3, -5, 5, 100, 200), mk_box(2'd3, -5, 5, 100, 200));
    add_pair(KIND_UNION, mk_box(2'd3, -5, 5, 100, 200), mk_box(2'd3, -5, 5, 100, 200));
    add_pair(KIND_INTERSECT, mk_box(2'd3, BND_MIN, BND_MAX, BND_MIN, BND_MAX),
             mk_box(2'd3, 0, 0, 0, 0));
    add_pair(KIND_UNION, mk_box(2'd3, 0, 0, 0, 0),
             mk_box(2'd3, BND_MIN, BND_MAX, BND_MIN, BND_MAX));
    add_pair(KIND_INTERSECT, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd3, 20, 30, 0, 10));
    add_pair(KIND_UNION, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd3, 20, 30, 0, 10));
    add_pair(KIND_INTERSECT, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd3, 10, 30, 5, 8));
    add_pair(KIND_UNION, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd3, 4, 30, 10, 20));
    // time only and value only, before/after and left/right
    add_pair(KIND_INTERSECT, mk_box(2'd2, '1, '1, 0, 9), mk_box(2'd2, 0, 0, 50, 60));
    add_pair(KIND_UNION, mk_box(2'd2, 7, 7, 50, 60), mk_box(2'd2, 7, 7, 0, 9));
    add_pair(KIND_INTERSECT, mk_box(2'd1, -40, -30, 3, 3), mk_box(2'd1, -20, 0, 3, 3));
    add_pair(KIND_UNION, mk_box(2'd1, BND_MAX, BND_MAX, 0, 0), mk_box(2'd1, BND_MIN, 0, 0, 0));
    // no common dimension
    add_pair(KIND_INTERSECT, mk_box(2'd1, 0, 5, 0, 5), mk_box(2'd2, 0, 5, 0, 5));
    add_pair(KIND_UNION, mk_box(2'd2, 0, 5, 0, 5), mk_box(2'd1, 0, 5, 0, 5));
    // boxes with no dimension at all
    add_pair(KIND_INTERSECT, mk_box(FLG_NONE, 1, 2, 3, 4), mk_box(FLG_NONE, 1, 2, 3, 4));
    add_pair(KIND_UNION, mk_box(FLG_NONE, 1, 2, 3, 4), mk_box(FLG_NONE, 1, 2, 3, 4));
    add_pair(KIND_UNION, mk_box(FLG_NONE, 0, 0, 0, 0), mk_box(2'd3, 0, 0, 0, 0));
    // flags differ but overlap in the shared dimension
    add_pair(KIND_UNION, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd1, 2, 3, 99, 99));
    add_pair(KIND_INTERSECT, mk_box(2'd3, 0, 10, 0, 10), mk_box(2'd1, 2, 3, 99, 99));
    // inverted spans are taken as given
    add_pair(KIND_INTERSECT, mk_box(2'd3, 10, 0, 10, 0), mk_box(2'd3, 5, 5, 5, 5));
    add_pair(KIND_UNION, mk_box(2'd3, 10, 0, 10, 0), mk_box(2'd3, 10, 0, 10, 0));
    // equal boxes, and boxes equal except an absent bound
    add_pair(KIND_INTERSECT, mk_box(2'd1, 1, 2, 3, 4), mk_box(2'd1, 1, 2, 3, 5));
    add_pair(KIND_UNION, mk_box(2'd3, '1, '1, BND_MIN, BND_MIN),
             mk_box(2'd3, '1, '1, BND_MIN, BND_MIN));
    for (int i = 0; i < RAND_PAIRS; i++)
      pending_pairs.push_back(rand_pair());

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_pairs.size() != 0 || start || expected_results.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
    if (mismatches == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
